@@ hw/rtl/rlh_pkg.sv @@
package rlh_pkg;

	// width of the running value and of the limit register
	localparam int unsigned HP_W = 31;

	// width of the period port
	localparam int unsigned PERIOD_W = 16;

	// largest value that fits in the running register
	localparam logic [HP_W-1:0] HP_MAX = {HP_W{1'b1}};

	// limit register value after reset
	localparam logic [HP_W-1:0] LIMIT_RESET = 31'd2147483646;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIV,
		ST_MUL,
		ST_WB
	} rlh_state_t;

endpackage

@@ hw/rtl/rlh_gcd.sv @@
module rlh_gcd (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rlh_pkg::HP_W-1:0]    a_in,
	input  logic [rlh_pkg::HP_W-1:0]    b_in,
	output logic                        done,
	output logic [rlh_pkg::HP_W-1:0]    gcd
);

	localparam int unsigned KW = $clog2(rlh_pkg::HP_W);

	logic                     busy_q;
	logic                     done_q;
	logic [rlh_pkg::HP_W-1:0] a_q;
	logic [rlh_pkg::HP_W-1:0] b_q;
	logic [rlh_pkg::HP_W-1:0] gcd_q;
	logic [KW-1:0]            k_q;
	logic                     a_ge_b;
	logic [rlh_pkg::HP_W-1:0] diff_ab;
	logic [rlh_pkg::HP_W-1:0] diff_ba;

	// one subtract and compare per step
	assign a_ge_b  = (a_q >= b_q);
	assign diff_ab = a_q - b_q;
	assign diff_ba = b_q - a_q;

	// control: busy until one operand reaches zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && ((a_q == '0) || (b_q == '0))) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// binary gcd datapath, one bit of reduction per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_in;
			b_q <= b_in;
			k_q <= '0;
		end else if (busy_q) begin
			if (a_q == '0) begin
				gcd_q <= b_q << k_q;
			end else if (b_q == '0) begin
				gcd_q <= a_q << k_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_ge_b) begin
				a_q <= diff_ab >> 1;
			end else begin
				b_q <= diff_ba >> 1;
			end
		end
	end

	assign done = done_q;
	assign gcd  = gcd_q;

endmodule

@@ hw/rtl/rlh_div.sv @@
module rlh_div #(
	parameter int unsigned W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int unsigned CW = $clog2(W);

	logic         busy_q;
	logic         done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] dvs_q;
	logic [W:0]   rem_q;
	logic [W:0]   rem_sh;
	logic [W:0]   rem_sub;
	logic         fits;

	// restoring step: shift in the next dividend bit, try the subtract
	assign rem_sh  = {rem_q[W-1:0], quo_q[W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign fits    = (rem_sh >= {1'b0, dvs_q});

	// control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/rlh_mul.sv @@
module rlh_mul #(
	parameter int unsigned QW = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [QW-1:0]                     multiplier,
	input  logic [rlh_pkg::HP_W-1:0]          multiplicand,
	output logic                              done,
	output logic [rlh_pkg::HP_W+QW-1:0]       product
);

	localparam int unsigned PW = rlh_pkg::HP_W + QW;
	localparam int unsigned CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] mlt_q;
	logic [PW-1:0] mcd_q;
	logic [PW-1:0] acc_q;

	// control: one multiplier bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add: multiplier shifts right, multiplicand shifts left
	always_ff @(posedge clk) begin
		if (start) begin
			mlt_q <= multiplier;
			mcd_q <= PW'(multiplicand);
			acc_q <= '0;
		end else if (busy_q) begin
			if (mlt_q[0]) begin
				acc_q <= acc_q + mcd_q;
			end
			mlt_q <= mlt_q >> 1;
			mcd_q <= mcd_q << 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

@@ hw/rtl/running_lcm_hyperperiod.sv @@
// result side free: a first period, a period before any set or one in a saturated set reaches the
//   registered result in the cycle after the input transfer; any other period passes through the
//   serial gcd, divider and multiplier first
// throughput: one period at a time; the next is taken the cycle after the result registers
// reset: arst_n clears the running value, the overflow flag and the output valid;
//   the limit register returns to 2147483646
module running_lcm_hyperperiod #(
	parameter int unsigned PERIOD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              hyperperiod_limit_we,
	input  logic [rlh_pkg::HP_W-1:0]          hyperperiod_limit_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [rlh_pkg::PERIOD_W-1:0]      period,
	input  logic                              first,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [rlh_pkg::HP_W-1:0]          hyperperiod,
	output logic                              saturated,
	output logic                              within_limit
);

	localparam int unsigned PW = rlh_pkg::HP_W + PERIOD_BITS;

	rlh_pkg::rlh_state_t state_q, state_nxt;

	logic [rlh_pkg::HP_W-1:0] limit_q;
	logic [rlh_pkg::HP_W-1:0] run_q;
	logic                     ovf_q;
	logic [PERIOD_BITS-1:0]   p_q;
	logic [rlh_pkg::HP_W-1:0] res_q;
	logic                     res_ovf_q;
	logic                     out_valid_q;
	logic [rlh_pkg::HP_W-1:0] hp_q;
	logic                     sat_q;
	logic                     within_q;

	logic [rlh_pkg::HP_W-1:0] period_ext;
	logic [PERIOD_BITS-1:0]   p_raw;
	logic [PERIOD_BITS-1:0]   p_eff;
	logic [rlh_pkg::HP_W-1:0] sat_val;
	logic                     accept;
	logic                     fast_path;
	logic                     out_free;
	logic                     gcd_start;
	logic                     div_start;
	logic                     mul_start;
	logic                     wb_en;
	logic                     gcd_done;
	logic [rlh_pkg::HP_W-1:0] gcd_res;
	logic                     div_done;
	logic [PERIOD_BITS-1:0]   quo;
	logic                     mul_done;
	logic [PW-1:0]            prod;
	logic                     prod_ovf;

	// period masked to PERIOD_BITS, zero taken as one
	assign period_ext = rlh_pkg::HP_W'(period);
	assign p_raw      = period_ext[PERIOD_BITS-1:0];
	assign p_eff      = (p_raw == '0) ? PERIOD_BITS'(1) : p_raw;

	// saturation value, clamped at the register maximum
	assign sat_val = (limit_q == rlh_pkg::HP_MAX) ? rlh_pkg::HP_MAX
		: limit_q + rlh_pkg::HP_W'(1);

	assign accept    = in_valid && !in_stall;
	assign fast_path = first || (run_q == '0) || ovf_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign prod_ovf  = |prod[PW-1:rlh_pkg::HP_W];

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rlh_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = fast_path ? rlh_pkg::ST_WB : rlh_pkg::ST_GCD;
				end
			end
			rlh_pkg::ST_GCD: begin
				if (gcd_done) begin
					state_nxt = rlh_pkg::ST_DIV;
				end
			end
			rlh_pkg::ST_DIV: begin
				if (div_done) begin
					state_nxt = rlh_pkg::ST_MUL;
				end
			end
			rlh_pkg::ST_MUL: begin
				if (mul_done) begin
					state_nxt = rlh_pkg::ST_WB;
				end
			end
			rlh_pkg::ST_WB: begin
				if (out_free) begin
					state_nxt = rlh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = rlh_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		gcd_start = 1'b0;
		div_start = 1'b0;
		mul_start = 1'b0;
		wb_en     = 1'b0;
		case (state_q)
			rlh_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				gcd_start = in_valid && !fast_path;
			end
			rlh_pkg::ST_GCD: begin
				div_start = gcd_done;
			end
			rlh_pkg::ST_DIV: begin
				mul_start = div_done;
			end
			rlh_pkg::ST_MUL: begin
			end
			rlh_pkg::ST_WB: begin
				wb_en = out_free;
			end
			default: begin
			end
		endcase
	end

	// state, running value, limit register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlh_pkg::ST_IDLE;
			limit_q     <= rlh_pkg::LIMIT_RESET;
			run_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (hyperperiod_limit_we) begin
				limit_q <= hyperperiod_limit_wdata;
			end
			if (wb_en) begin
				run_q       <= res_q;
				ovf_q       <= res_ovf_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pending result and period of the item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q <= p_eff;
			if (first || (run_q == '0)) begin
				res_q     <= rlh_pkg::HP_W'(p_eff);
				res_ovf_q <= 1'b0;
			end else if (ovf_q) begin
				res_q     <= sat_val;
				res_ovf_q <= 1'b1;
			end
		end else if ((state_q == rlh_pkg::ST_MUL) && mul_done) begin
			res_q     <= prod_ovf ? sat_val : prod[rlh_pkg::HP_W-1:0];
			res_ovf_q <= prod_ovf;
		end
	end

	// output register for the result transfer
	always_ff @(posedge clk) begin
		if (wb_en) begin
			hp_q     <= res_q;
			sat_q    <= res_ovf_q;
			within_q <= (res_q < limit_q);
		end
	end

	rlh_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a_in   (rlh_pkg::HP_W'(p_eff)),
		.b_in   (run_q),
		.done   (gcd_done),
		.gcd    (gcd_res)
	);

	rlh_div #(
		.W (PERIOD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (p_q),
		.divisor  (gcd_res[PERIOD_BITS-1:0]),
		.done     (div_done),
		.quotient (quo)
	);

	rlh_mul #(
		.QW (PERIOD_BITS)
	) u_mul (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (mul_start),
		.multiplier   (quo),
		.multiplicand (run_q),
		.done         (mul_done),
		.product      (prod)
	);

	assign out_valid    = out_valid_q;
	assign hyperperiod  = hp_q;
	assign saturated    = sat_q;
	assign within_limit = within_q;

endmodule

@@ tb/running_lcm_hyperperiod_test.sv @@
`timescale 1ns / 100ps

module running_lcm_hyperperiod_test;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned DRAIN_CYCLES = 150;
	localparam int unsigned ITEMS_PER_PHASE = 210;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned HOLD_AFTER = 300;
	localparam int unsigned HOLD_CYCLES = 800;

	typedef struct packed {
		logic [rlh_pkg::HP_W-1:0] hp;
		logic                     sat;
		logic                     wl;
	} lcm_result_t;

	typedef enum logic {
		ROW_PERIOD,
		ROW_LIMIT
	} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [rlh_pkg::HP_W-1:0] value;
		logic                     f;
		logic                     typed;
		lcm_result_t              want;
	} dir_row_t;

	localparam lcm_result_t NO_WANT = '0;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         hyperperiod_limit_we;
	logic [rlh_pkg::HP_W-1:0]     hyperperiod_limit_wdata;
	logic                         in_valid;
	logic                         in_stall;
	logic [rlh_pkg::PERIOD_W-1:0] period;
	logic                         first;
	logic                         out_valid;
	logic                         out_stall;
	logic [rlh_pkg::HP_W-1:0]     hyperperiod;
	logic                         saturated;
	logic                         within_limit;

	// predictor state and scoreboard
	logic [rlh_pkg::HP_W-1:0] lcm_run;
	logic                     lcm_ovf;
	logic [rlh_pkg::HP_W-1:0] limit_copy;
	lcm_result_t              pending_lcm[$];

	logic        quiet = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned saturated_seen = 0;
	int unsigned within_seen = 0;
	int unsigned periods_sent = 0;
	int unsigned sets_started = 0;
	int unsigned limit_writes = 0;

	// directed stimulus: extremes, zero period, saturation, limit corners
	dir_row_t directed_rows[$] = '{
		'{ROW_PERIOD, 31'd12,         1'b0, 1'b1, '{31'd12, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd18,         1'b0, 1'b1, '{31'd36, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd0,          1'b0, 1'b1, '{31'd36, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd65535,      1'b1, 1'b1, '{31'd65535, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd65521,      1'b0, 1'b1, '{31'd2147483647, 1'b1, 1'b0}},
		'{ROW_PERIOD, 31'd1,          1'b0, 1'b1, '{31'd2147483647, 1'b1, 1'b0}},
		'{ROW_PERIOD, 31'd0,          1'b1, 1'b1, '{31'd1, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd32768,      1'b0, 1'b1, '{31'd32768, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd65535,      1'b0, 1'b1, '{31'd2147450880, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd3,          1'b0, 1'b1, '{31'd2147450880, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd7,          1'b0, 1'b1, '{31'd2147483647, 1'b1, 1'b0}},
		'{ROW_LIMIT,  31'd2147483647, 1'b0, 1'b0, NO_WANT},
		'{ROW_PERIOD, 31'd65521,      1'b1, 1'b1, '{31'd65521, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd65519,      1'b0, 1'b1, '{31'd2147483647, 1'b1, 1'b0}},
		'{ROW_PERIOD, 31'd2,          1'b0, 1'b1, '{31'd2147483647, 1'b1, 1'b0}},
		'{ROW_LIMIT,  31'd0,          1'b0, 1'b0, NO_WANT},
		'{ROW_PERIOD, 31'd5,          1'b1, 1'b1, '{31'd5, 1'b0, 1'b0}},
		'{ROW_PERIOD, 31'd40000,      1'b0, 1'b1, '{31'd40000, 1'b0, 1'b0}},
		'{ROW_PERIOD, 31'd65535,      1'b0, 1'b0, NO_WANT},
		'{ROW_LIMIT,  31'd1,          1'b0, 1'b0, NO_WANT},
		'{ROW_PERIOD, 31'd1,          1'b1, 1'b1, '{31'd1, 1'b0, 1'b0}},
		'{ROW_PERIOD, 31'd100,        1'b1, 1'b1, '{31'd100, 1'b0, 1'b0}},
		'{ROW_PERIOD, 31'd65535,      1'b0, 1'b0, NO_WANT},
		'{ROW_PERIOD, 31'h0000AAAA,   1'b0, 1'b0, NO_WANT},
		'{ROW_LIMIT,  31'd1000,       1'b0, 1'b0, NO_WANT},
		'{ROW_PERIOD, 31'd999,        1'b1, 1'b1, '{31'd999, 1'b0, 1'b1}},
		'{ROW_PERIOD, 31'd1000,       1'b0, 1'b1, '{31'd999000, 1'b0, 1'b0}},
		'{ROW_PERIOD, 31'h00005555,   1'b0, 1'b1, '{31'd1001, 1'b1, 1'b0}},
		'{ROW_PERIOD, 31'd9,          1'b0, 1'b1, '{31'd1001, 1'b1, 1'b0}}
	};

	running_lcm_hyperperiod uut (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.hyperperiod_limit_we    (hyperperiod_limit_we),
		.hyperperiod_limit_wdata (hyperperiod_limit_wdata),
		.in_valid                (in_valid),
		.in_stall                (in_stall),
		.period                  (period),
		.first                   (first),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.hyperperiod             (hyperperiod),
		.saturated               (saturated),
		.within_limit            (within_limit)
	);

	always #5 clk = ~clk;

	// run-length guard
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// value held once a set has overflowed, clamped when the limit is all ones
	function automatic logic [rlh_pkg::HP_W-1:0] sat_level();
		return (limit_copy == rlh_pkg::HP_MAX) ? rlh_pkg::HP_MAX : limit_copy + 1'b1;
	endfunction

	// fold one period into the running lcm and return the expected result
	function automatic lcm_result_t fold_period(input logic [rlh_pkg::PERIOD_W-1:0] p_in,
			input logic f);
		logic [31:0] p;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] t;
		logic [63:0] prod;
		lcm_result_t r;
		p = 32'(p_in);
		if (p == 0)
			p = 1;
		if (f || lcm_run == 0) begin
			lcm_run = p[rlh_pkg::HP_W-1:0];
			lcm_ovf = 1'b0;
		end else if (lcm_ovf) begin
			lcm_run = sat_level();
		end else begin
			a = p;
			b = {1'b0, lcm_run};
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			prod = 64'(p / a) * 64'(lcm_run);
			if (prod > 64'(rlh_pkg::HP_MAX)) begin
				lcm_ovf = 1'b1;
				lcm_run = sat_level();
			end else begin
				lcm_run = prod[rlh_pkg::HP_W-1:0];
			end
		end
		r.hp = lcm_run;
		r.sat = lcm_ovf;
		r.wl = (lcm_run < limit_copy);
		return r;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// period mix: small primes and composites, shifted multiples, powers of two, wide values, zero
	function automatic logic [rlh_pkg::PERIOD_W-1:0] pick_period();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return rlh_pkg::PERIOD_W'($urandom_range(1, 24));
		if (r < 45)
			return rlh_pkg::PERIOD_W'($urandom_range(1, 24) << $urandom_range(0, 10));
		if (r < 65)
			return rlh_pkg::PERIOD_W'($urandom());
		if (r < 75)
			return rlh_pkg::PERIOD_W'(1 << $urandom_range(0, rlh_pkg::PERIOD_W - 1));
		if (r < 85)
			return rlh_pkg::PERIOD_W'($urandom_range(60000, 65535));
		if (r < 90)
			return '0;
		return rlh_pkg::PERIOD_W'($urandom_range(25, 2000));
	endfunction

	// write the limit once every pending result has drained
	task automatic write_limit(input logic [rlh_pkg::HP_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_lcm.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		hyperperiod_limit_we <= 1'b1;
		hyperperiod_limit_wdata <= v;
		@(posedge clk);
		hyperperiod_limit_we <= 1'b0;
		limit_copy = v;
		limit_writes++;
	endtask

	// one period transfer; expectation queued at acceptance
	task automatic send_period(input logic [rlh_pkg::PERIOD_W-1:0] p, input logic f,
			input logic typed, input lcm_result_t want);
		int unsigned g;
		lcm_result_t got;
		g = pick_gap();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		period <= p;
		first <= f;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = fold_period(p, f);
		pending_lcm.push_back(typed ? want : got);
		periods_sent++;
		if (f)
			sets_started++;
	endtask

	// stimulus: reset, directed table, then random phases with new limits
	initial begin : stimulus
		int unsigned phase;
		int unsigned sent;
		int unsigned n;
		logic [rlh_pkg::HP_W-1:0] new_limit;
		arst_n = 1'b0;
		hyperperiod_limit_we = 1'b0;
		hyperperiod_limit_wdata = '0;
		in_valid = 1'b0;
		period = '0;
		first = 1'b0;
		lcm_run = '0;
		lcm_ovf = 1'b0;
		limit_copy = rlh_pkg::LIMIT_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_LIMIT)
				write_limit(directed_rows[i].value);
			else
				send_period(rlh_pkg::PERIOD_W'(directed_rows[i].value),
					directed_rows[i].f, directed_rows[i].typed, directed_rows[i].want);
		end

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: new_limit = rlh_pkg::HP_W'($urandom());
				1: new_limit = rlh_pkg::HP_W'(1);
				2: new_limit = rlh_pkg::HP_MAX;
				3: new_limit = '0;
				4: new_limit = rlh_pkg::HP_W'($urandom_range(1, 100000));
				5: new_limit = rlh_pkg::HP_W'($urandom());
				6: new_limit = rlh_pkg::LIMIT_RESET;
				default: new_limit = rlh_pkg::HP_W'($urandom_range(1000, 50000000));
			endcase
			write_limit(new_limit);
			quiet = (phase == 2 || phase == 5);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: loose items with a random set marker
					n = $urandom_range(1, 4);
					repeat (n) send_period(pick_period(), 1'(($urandom())), 1'b0, NO_WANT);
				end else begin
					// well-formed task set, now and then a long one
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30)
						: $urandom_range(1, 12);
					send_period(pick_period(), 1'b1, 1'b0, NO_WANT);
					repeat (n - 1) send_period(pick_period(), 1'b0, 1'b0, NO_WANT);
				end
				sent += n;
			end
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		while (pending_lcm.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d periods in %0d task sets over %0d limit settings",
			periods_sent, sets_started, limit_writes);
		$display("summary: %0d results checked, %0d saturated, %0d within limit",
			results_seen, saturated_seen, within_seen);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// result side: random stalls plus one long hold-off to back up the input
	initial begin : result_sink
		int unsigned g;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				g = pick_gap();
				if (g != 0) begin
					out_stall <= 1'b1;
					repeat (g) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	// compare each result transfer against the oldest expectation
	always @(posedge clk) begin : check_results
		lcm_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (saturated)
				saturated_seen++;
			if (within_limit)
				within_seen++;
			if (pending_lcm.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result hyperperiod=%0d saturated=%0b within_limit=%0b",
					$time, hyperperiod, saturated, within_limit);
			end else begin
				want = pending_lcm.pop_front();
				if (hyperperiod !== want.hp) begin
					mismatches++;
					$display("%0t: hyperperiod expected %0d actual %0d",
						$time, want.hp, hyperperiod);
				end
				if (saturated !== want.sat) begin
					mismatches++;
					$display("%0t: saturated expected %0b actual %0b",
						$time, want.sat, saturated);
				end
				if (within_limit !== want.wl) begin
					mismatches++;
					$display("%0t: within_limit expected %0b actual %0b",
						$time, want.wl, within_limit);
				end
			end
		end
	end

endmodule

@@ filelist.f @@
hw/rtl/rlh_pkg.sv
hw/rtl/rlh_gcd.sv
hw/rtl/rlh_div.sv
hw/rtl/rlh_mul.sv
hw/rtl/running_lcm_hyperperiod.sv
tb/running_lcm_hyperperiod_test.sv
